[sv/bounded_min_priority_queue_defines.svh]
// Assertion helpers shared by the queue RTL.
// All checks are clocked on clk and switched off while rst is high.
`ifndef BOUNDED_MIN_PRIORITY_QUEUE_DEFINES_SVH
`define BOUNDED_MIN_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define BMPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BMPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/bmpq_pkg.sv]
package bmpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // child index math needs room for 2*pos+2
  localparam int IDX_W    = ADDR_W + 2;
  localparam int KEY_W    = 32;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [IDX_W-1:0]        idx_t;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_FIND   = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_CMP,
    S_FIND,
    S_RESP
  } state_t;

  // one write port, two registered read ports
  typedef struct packed {
    logic  we;
    addr_t waddr;
    key_t  wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } mem_req_t;

  typedef struct packed {
    key_t    key;
    status_t status;
    count_t  count;
  } result_t;

endpackage

[sv/bmpq_store.sv]
module bmpq_store import bmpq_pkg::*; (
  input  logic     clk,
  input  mem_req_t mem,
  output key_t     rdata_a,
  output key_t     rdata_b
);

  key_t ram [CAPACITY];

  always_ff @(posedge clk) begin
    if (mem.we) begin
      ram[mem.waddr] <= mem.wdata;
    end
    rdata_a <= ram[mem.raddr_a];
    rdata_b <= ram[mem.raddr_b];
  end

endmodule

[sv/bmpq_engine.sv]
`include "bounded_min_priority_queue_defines.svh"

module bmpq_engine import bmpq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  func_t    fn,
  input  key_t     key,
  input  logic     out_free,
  output logic     idle,
  output logic     done,
  output result_t  res,
  output mem_req_t mem,
  input  key_t     rdata_a,
  input  key_t     rdata_b
);

  state_t  state, state_next;
  count_t  count, count_next;
  addr_t   pos;
  key_t    v;
  key_t    res_key;
  status_t res_status;

  logic    full, empty;
  count_t  cnt_m1;
  addr_t   par, gpar;
  logic    up_stop;
  idx_t    c1, c2, cidx, gc1, gc2;
  logic    has1, has2, pick_b, dn_stop;
  key_t    pick;
  logic    ins_ok;

  assign full   = (count == count_t'(CAPACITY));
  assign empty  = (count == '0);
  assign cnt_m1 = count - count_t'(1);
  assign ins_ok = start && idle && (fn == FN_INSERT) && !full;

  // sift-up: parent and grandparent of pos
  assign par     = (pos - addr_t'(1)) >> 1;
  assign gpar    = (par - addr_t'(1)) >> 1;
  assign up_stop = (rdata_a <= v);

  // sift-down: children of pos, count is already the post-delete count
  assign c1      = idx_t'({pos, 1'b1});
  assign c2      = c1 + idx_t'(1);
  assign has1    = c1 < idx_t'(count);
  assign has2    = c2 < idx_t'(count);
  assign pick_b  = has2 && (rdata_b < rdata_a);
  assign pick    = pick_b ? rdata_b : rdata_a;
  assign cidx    = pick_b ? c2 : c1;
  assign dn_stop = !has1 || (pick >= v);
  assign gc1     = idx_t'({cidx, 1'b1});
  assign gc2     = gc1 + idx_t'(1);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (fn)
            FN_INSERT: state_next = full  ? S_RESP : S_UP_RD;
            FN_DELETE: state_next = empty ? S_RESP : S_DN_LOAD;
            FN_FIND:   state_next = empty ? S_RESP : S_FIND;
            default:   state_next = S_RESP;
          endcase
        end
      end
      S_UP_RD:   state_next = (pos == '0) ? S_RESP : S_UP_CMP;
      S_UP_CMP: begin
        if (up_stop) begin
          state_next = S_RESP;
        end else if (par == '0) begin
          state_next = S_UP_RD;
        end
      end
      S_DN_LOAD: state_next = empty ? S_RESP : S_DN_CMP;
      S_DN_CMP:  state_next = dn_stop ? S_RESP : S_DN_CMP;
      S_FIND:    state_next = S_RESP;
      S_RESP:    state_next = out_free ? S_IDLE : S_RESP;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem         = '0;
    count_next  = count;
    idle        = (state == S_IDLE);
    done        = (state == S_RESP) && out_free;
    res.key     = res_key;
    res.status  = res_status;
    res.count   = count;
    case (state)
      S_IDLE: begin
        // root and last entry, ready for delete or find
        mem.raddr_a = '0;
        mem.raddr_b = cnt_m1[ADDR_W-1:0];
        if (start) begin
          case (fn)
            FN_INSERT: if (!full) count_next = count + count_t'(1);
            FN_DELETE: if (!empty) count_next = cnt_m1;
            FN_CLEAR:  count_next = '0;
            default:   count_next = count;
          endcase
        end
      end
      S_UP_RD: begin
        mem.raddr_a = par;
        if (pos == '0) begin
          mem.we    = 1'b1;
          mem.waddr = pos;
          mem.wdata = v;
        end
      end
      S_UP_CMP: begin
        mem.we      = 1'b1;
        mem.waddr   = pos;
        mem.wdata   = up_stop ? v : rdata_a;
        mem.raddr_a = gpar;
      end
      S_DN_LOAD: begin
        mem.raddr_a = addr_t'(1);
        mem.raddr_b = addr_t'(2);
      end
      S_DN_CMP: begin
        mem.we      = 1'b1;
        mem.waddr   = pos;
        mem.wdata   = dn_stop ? v : pick;
        mem.raddr_a = gc1[ADDR_W-1:0];
        mem.raddr_b = gc2[ADDR_W-1:0];
      end
      default: begin
        mem.raddr_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          res_key <= '0;
          case (fn)
            FN_INSERT: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_OK;
                pos        <= count[ADDR_W-1:0];
                v          <= key;
              end
            end
            FN_DELETE, FN_FIND: begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else begin
                res_status <= ST_OK;
              end
            end
            default: res_status <= ST_OK;
          endcase
        end
      end
      S_UP_CMP: begin
        if (!up_stop) pos <= par;
      end
      S_DN_LOAD: begin
        res_key <= rdata_a;
        v       <= rdata_b;
        pos     <= '0;
      end
      S_DN_CMP: begin
        if (!dn_stop) pos <= cidx[ADDR_W-1:0];
      end
      S_FIND: begin
        res_key <= rdata_a;
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

  `BMPQ_ASSERT_NOW(a_wr_in_heap, mem.we, {1'b0, mem.waddr} < count, "store write outside heap")
  `BMPQ_ASSERT_NEXT(a_done_idle, done, state == S_IDLE, "engine not idle after result")
  `BMPQ_ASSERT_NEXT(a_ins_count, ins_ok, count == $past(count) + count_t'(1), "count stuck")

endmodule

[sv/bounded_min_priority_queue.sv]
// Bounded min-priority queue of signed 32-bit keys, 1024 entries.
//
// Request channel: req_valid/req_stall carry func (insert, delete-min,
// find-min, clear) and key_in. A request is taken on a rising edge with
// req_valid high and req_stall low. Every request yields one response on
// rsp_valid/rsp_stall with key_out, status and count_out (keys held after).
//
// Keys live in a binary heap in a 1W/2R synchronous RAM. Insert walks up
// one level per cycle, delete walks down one level per cycle, both doing
// read-compare-write in a single pass per level; the shared RAM write port
// sets the pace. Path from accept to response valid:
//   clear, full insert, empty delete/find: straight to the response
//   find, and a delete that takes the last key: a read of the root first
//   insert: a parent read, then a step per level climbed
//   delete: a root and last-key load, then a step per level descended
// One request at a time: the engine takes the next one in the cycle after
// it hands its result over.
// Reset (rst, synchronous) empties the queue; RAM contents are not cleared.
// A stalled response holds; the engine then waits in its result state and
// req_stall stays high until the output register frees up.
`include "bounded_min_priority_queue_defines.svh"

module bounded_min_priority_queue import bmpq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         func,
  input  logic signed [31:0] key_in,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] key_out,
  output logic [1:0]         status,
  output logic [CNT_W-1:0]   count_out
);

  logic     eng_idle;
  logic     eng_done;
  logic     out_free;
  logic     start;
  result_t  eng_res;
  mem_req_t mem;
  key_t     rdata_a;
  key_t     rdata_b;

  // output register is free when empty or being drained this cycle
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !eng_idle;
  assign start     = req_valid && eng_idle;

  bmpq_store u_store (
    .clk     (clk),
    .mem     (mem),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  bmpq_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .fn       (func_t'(func)),
    .key      (key_in),
    .out_free (out_free),
    .idle     (eng_idle),
    .done     (eng_done),
    .res      (eng_res),
    .mem      (mem),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (eng_done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done) begin
      key_out   <= eng_res.key;
      status    <= eng_res.status;
      count_out <= eng_res.count;
    end
  end

  `BMPQ_ASSERT_NOW(a_no_overwrite, eng_done, out_free, "result loaded over a held response")

endmodule
